// ----- design/skewed_cuckoo_hash_table_assert.svh -----
// Assertion macros used by the checker file.
`ifndef SKEWED_CUCKOO_HASH_TABLE_ASSERT_SVH
`define SKEWED_CUCKOO_HASH_TABLE_ASSERT_SVH
// Implication checked on every rising clock edge, off during reset.
`define SCH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, off during reset.
`define SCH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- design/sch_pkg.sv -----
// ---------------------------------------------------------------------------
// sch_pkg
// Widths, entry layout and hash functions of the skewed cuckoo table.
// ---------------------------------------------------------------------------
`default_nettype none
package sch_pkg;
	localparam int IndexBits  = 10;
	localparam int TagWidth   = 16;
	localparam int KeyWidth   = 32;
	localparam int ValueWidth = 32;
	localparam int EntryWidth = ValueWidth + TagWidth + IndexBits;
	localparam int Depth      = 1 << IndexBits;
	localparam int Chunks     = KeyWidth / IndexBits;
	localparam logic [7:0] KicksReset = 8'd32;

	typedef logic [IndexBits-1:0] idx_t;
	typedef struct packed {
		logic [ValueWidth-1:0] val;
		logic [TagWidth-1:0]   tag;
		idx_t                  idx;
	} entry_t;

	function automatic idx_t skew_down(idx_t x);
		return {x[IndexBits-1] ^ x[0], x[IndexBits-1:1]};
	endfunction

	function automatic idx_t skew_up(idx_t x);
		return {x[IndexBits-2:0], x[IndexBits-1] ^ x[IndexBits-2]};
	endfunction

	function automatic idx_t chunk(logic [KeyWidth-1:0] k, int i);
		return idx_t'(k >> (IndexBits * i));
	endfunction

	// Chunk fold: Chunks steps of skewed XOR, narrow values.
	function automatic idx_t hash_first(logic [KeyWidth-1:0] k);
		idx_t acc;
		idx_t part;
		acc = chunk(k, 0);
		for (int i = 1; i < Chunks; i++) begin
			part = chunk(k, i);
			acc = skew_down(acc) ^ skew_up(part) ^ part;
		end
		part = idx_t'(k >> (KeyWidth - IndexBits));
		return skew_down(acc) ^ skew_up(part) ^ part;
	endfunction

	function automatic idx_t hash_second(logic [KeyWidth-1:0] k);
		idx_t acc;
		idx_t part;
		acc = chunk(k, 0);
		for (int i = 1; i < Chunks; i++) begin
			part = chunk(k, i);
			acc = skew_down(acc) ^ skew_up(part) ^ acc;
		end
		part = idx_t'(k >> (KeyWidth - IndexBits));
		return skew_down(acc) ^ skew_up(part) ^ acc;
	endfunction
endpackage
`default_nettype wire

// ----- design/sch_ram.sv -----
// ---------------------------------------------------------------------------
// sch_ram
// Single-port synchronous RAM, registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module sch_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ----- design/skewed_cuckoo_hash_table.sv -----
// Lookup, update and insert into a free slot: the input transfer is followed by
// the states HASH, RD and CMP (hash, read, compare/write), then the result.
// Insert that evicts: CMP enters the kick check KCHK; each eviction then
// goes KCHK (write), KWAIT, KRD (reread); result follows the final check.
// One item at a time; next item accepted once the result is taken. Reset: both
// tables swept clear, no item accepted; kicks_q resets to 32.
// ---------------------------------------------------------------------------
// skewed_cuckoo_hash_table
// Two-table cuckoo map with skewed hashes, tag compare and bounded eviction.
// ---------------------------------------------------------------------------
`default_nettype none
module skewed_cuckoo_hash_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        req_type,
	input  wire logic [31:0] key,
	input  wire logic [31:0] value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             hit,
	output logic [31:0]      read_value,
	output logic             status
);
	typedef enum logic [3:0] {
		CLEAR, IDLE, HASH, RD, CMP, KRD, KCHK, KWAIT, DONE
	} state_t;

	state_t state_q;
	logic [7:0] kicks_q;
	logic [8:0] tried_q;            // evictions done, up to 256
	sch_pkg::idx_t clr_q, ha_q, hb_q;
	logic set_q;
	logic [sch_pkg::KeyWidth-1:0] key_q;
	sch_pkg::entry_t item_q;        // entry being placed

	// Table ports
	logic we_a, we_b;
	sch_pkg::idx_t addr_a, addr_b;
	sch_pkg::entry_t wd_a, wd_b, rd_a, rd_b;

	sch_ram #(.Width(sch_pkg::EntryWidth), .Depth(sch_pkg::Depth)) u_ram_a (
		.clk(clk), .we(we_a), .addr(addr_a), .wdata(wd_a), .rdata(rd_a));
	sch_ram #(.Width(sch_pkg::EntryWidth), .Depth(sch_pkg::Depth)) u_ram_b (
		.clk(clk), .we(we_b), .addr(addr_b), .wdata(wd_b), .rdata(rd_b));

	logic [sch_pkg::TagWidth-1:0] tag;
	logic empty_a, empty_b, in_a, in_b;
	assign tag     = key_q[sch_pkg::TagWidth-1:0];
	assign empty_a = (rd_a == '0);
	assign empty_b = (rd_b == '0);
	assign in_a    = !empty_a && rd_a.tag == tag;
	assign in_b    = !in_a && !empty_b && rd_b.tag == tag;

	// Memory control. Reads issue in RD/KRD; the next state sees data.
	always_comb begin
		we_a = 1'b0; we_b = 1'b0;
		addr_a = ha_q; addr_b = hb_q;
		wd_a = item_q; wd_b = item_q;
		wd_a.idx = hb_q; wd_b.idx = ha_q;
		case (state_q)
			CLEAR: begin
				we_a = 1'b1; we_b = 1'b1;
				addr_a = clr_q; addr_b = clr_q;
				wd_a = '0; wd_b = '0;
			end
			CMP: begin
				if (set_q) begin
					// update on match, or place in empty A / B
					we_a = in_a || (!in_b && empty_a);
					we_b = !we_a && (in_b || empty_b);
				end
			end
			KCHK: begin
				if (empty_a) begin
					we_a = 1'b1;
				end else if (empty_b) begin
					we_b = 1'b1;
				end else if ({1'b0, kicks_q} >= tried_q) begin
					we_a = tried_q[0];
					we_b = !tried_q[0];
				end
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= CLEAR;
			clr_q     <= '0;
			kicks_q   <= sch_pkg::KicksReset;
			out_valid <= 1'b0;
			tried_q   <= '0;
		end else begin
			if (cfg_we) begin
				kicks_q <= cfg_wdata;
			end
			case (state_q)
				CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (in_valid) begin
						set_q      <= req_type;
						key_q      <= key;
						item_q.val <= value;
						item_q.tag <= key[sch_pkg::TagWidth-1:0];
						item_q.idx <= '0;
						state_q    <= HASH;
					end
				end
				HASH: begin
					ha_q    <= sch_pkg::hash_first(key_q);
					hb_q    <= sch_pkg::hash_second(key_q);
					state_q <= RD;
				end
				RD: state_q <= CMP;
				CMP: begin
					hit        <= in_a || in_b;
					read_value <= (!set_q && in_a) ? rd_a.val :
						(!set_q && in_b) ? rd_b.val : '0;
					status     <= 1'b0;
					tried_q    <= '0;
					if (set_q && !in_a && !in_b && !empty_a && !empty_b) begin
						state_q <= KCHK;  // data of both slots still on rd ports
					end else begin
						out_valid <= 1'b1;
						state_q   <= DONE;
					end
				end
				KRD: state_q <= KCHK;
				KCHK: begin
					if (empty_a || empty_b) begin
						out_valid <= 1'b1;
						state_q   <= DONE;
					end else if ({1'b0, kicks_q} < tried_q) begin
						status    <= 1'b1;
						out_valid <= 1'b1;
						state_q   <= DONE;
					end else begin
						if (tried_q[0]) begin
							hb_q <= rd_a.idx;
							item_q <= rd_a;
						end else begin
							ha_q <= rd_b.idx;
							item_q <= rd_b;
						end
						tried_q <= tried_q + 1'b1;
						state_q <= KWAIT;
					end
				end
				KWAIT: state_q <= KRD;  // write settles before the reread
				DONE: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- design/sch_checker.sv -----
// ---------------------------------------------------------------------------
// sch_checker
// Port-level checks of the cuckoo table, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "skewed_cuckoo_hash_table_assert.svh"
module sch_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        hit,
	input wire logic [31:0] read_value,
	input wire logic        status
);
	`SCH_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(read_value))
	`SCH_ASSERT_IMP(a_one_busy, clk, arst_n, out_valid, !in_ready)
	`SCH_ASSERT_IMP(a_hit_ok, clk, arst_n, out_valid && status, !hit && read_value == 32'd0)
	`SCH_ASSERT_NXT(a_take_busy, clk, arst_n, in_valid && in_ready, !in_ready && !out_valid)
endmodule
bind skewed_cuckoo_hash_table sch_checker u_chk (.*);
`default_nettype wire

// ----- bench/tb_skewed_cuckoo_hash_table.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_skewed_cuckoo_hash_table
// Self-checking bench for the two-table cuckoo map. A local model of both
// tables predicts hit, read value and status per transfer. Stimulus runs in
// phases at different kick limits and stall patterns.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_skewed_cuckoo_hash_table;
	typedef struct {
		logic        req_type;
		logic [31:0] key;
		logic [31:0] value;
	} req_t;

	typedef struct {
		logic        hit;
		logic [31:0] read_value;
		logic        status;
	} rsp_t;

	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_SET    = 1'b1;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic        req_type;
	logic [31:0] key;
	logic [31:0] value;
	logic        out_valid;
	logic        out_ready;
	logic        hit;
	logic [31:0] read_value;
	logic        status;

	skewed_cuckoo_hash_table dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .key(key), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .read_value(read_value), .status(status)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Model state: shadow copies of both tables and the kick limit.
	sch_pkg::entry_t shadow_a [sch_pkg::Depth];
	sch_pkg::entry_t shadow_b [sch_pkg::Depth];
	logic [7:0]  kick_limit;

	req_t        pending_reqs[$];
	rsp_t        expected_rsps[$];
	int          errors;
	int          send_idle;
	int          recv_idle;
	logic        req_sent;

	// Skewed rotate right; new top bit is bit 0 xor old top bit.
	function automatic sch_pkg::idx_t skew_right(sch_pkg::idx_t x);
		sch_pkg::idx_t r;
		r = x >> 1;
		r[sch_pkg::IndexBits-1] = x[0] ^ x[sch_pkg::IndexBits-1];
		return r;
	endfunction

	// Shift left; new bit 0 is top bit xor the next one down.
	function automatic sch_pkg::idx_t skew_left(sch_pkg::idx_t x);
		sch_pkg::idx_t r;
		r = x << 1;
		r[0] = x[sch_pkg::IndexBits-1] ^ x[sch_pkg::IndexBits-2];
		return r;
	endfunction

	// Folds the key a chunk at a time; the second table feeds acc back in.
	function automatic sch_pkg::idx_t fold_key(logic [31:0] k, bit second);
		sch_pkg::idx_t acc;
		sch_pkg::idx_t part;
		acc = k[sch_pkg::IndexBits-1:0];
		for (int i = 1; i <= sch_pkg::Chunks; i++) begin
			if (i < sch_pkg::Chunks)
				part = sch_pkg::idx_t'(k >> (sch_pkg::IndexBits * i));
			else
				part = sch_pkg::idx_t'(k >> (sch_pkg::KeyWidth - sch_pkg::IndexBits));
			acc = skew_right(acc) ^ skew_left(part) ^ (second ? acc : part);
		end
		return acc;
	endfunction

	function automatic bit slot_free(sch_pkg::entry_t e);
		return e == '0;
	endfunction

	// Cuckoo placement; returns 0 when the displaced entry had to be dropped.
	function automatic bit place_entry(sch_pkg::idx_t ha, sch_pkg::idx_t hb,
			logic [31:0] v, logic [15:0] t);
		int              kicks;
		sch_pkg::entry_t old;
		kicks = 0;
		forever begin
			if (slot_free(shadow_a[ha])) begin
				shadow_a[ha] = '{val: v, tag: t, idx: hb};
				return 1'b1;
			end
			if (slot_free(shadow_b[hb])) begin
				shadow_b[hb] = '{val: v, tag: t, idx: ha};
				return 1'b1;
			end
			if (kicks > int'(kick_limit))
				return 1'b0;
			if (kicks % 2 == 1) begin
				old = shadow_a[ha];
				shadow_a[ha] = '{val: v, tag: t, idx: hb};
				hb = old.idx;
			end else begin
				old = shadow_b[hb];
				shadow_b[hb] = '{val: v, tag: t, idx: ha};
				ha = old.idx;
			end
			v = old.val;
			t = old.tag;
			kicks++;
		end
	endfunction

	function automatic rsp_t apply_request(req_t rq);
		rsp_t          r;
		sch_pkg::idx_t ha;
		sch_pkg::idx_t hb;
		logic [15:0]   t;
		bit            in_a;
		bit            in_b;
		r = '{hit: 1'b0, read_value: '0, status: 1'b0};
		t = rq.key[sch_pkg::TagWidth-1:0];
		ha = fold_key(rq.key, 1'b0);
		hb = fold_key(rq.key, 1'b1);
		in_a = !slot_free(shadow_a[ha]) && shadow_a[ha].tag == t;
		in_b = !in_a && !slot_free(shadow_b[hb]) && shadow_b[hb].tag == t;
		if (rq.req_type == REQ_LOOKUP) begin
			if (in_a) begin
				r.hit = 1'b1;
				r.read_value = shadow_a[ha].val;
			end else if (in_b) begin
				r.hit = 1'b1;
				r.read_value = shadow_b[hb].val;
			end
		end else if (in_a) begin
			shadow_a[ha] = '{val: rq.value, tag: t, idx: hb};
			r.hit = 1'b1;
		end else if (in_b) begin
			shadow_b[hb] = '{val: rq.value, tag: t, idx: ha};
			r.hit = 1'b1;
		end else if (!place_entry(ha, hb, rq.value, t)) begin
			r.status = 1'b1;
		end
		return r;
	endfunction

	// Monitor: config writes, accepted requests and result checks.
	always @(posedge clk) begin
		rsp_t got;
		rsp_t exp_r;
		req_sent <= in_valid && in_ready;
		if (arst_n) begin
			if (cfg_we)
				kick_limit = cfg_wdata;
			if (out_valid && out_ready) begin
				got = '{hit: hit, read_value: read_value, status: status};
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected result hit=%0b rv=%h st=%0b",
						$time, hit, read_value, status);
					errors++;
				end else begin
					exp_r = expected_rsps.pop_front();
					if (got.hit !== exp_r.hit) begin
						$display("%0t: hit expected %0b actual %0b",
							$time, exp_r.hit, got.hit);
						errors++;
					end
					if (got.read_value !== exp_r.read_value) begin
						$display("%0t: read_value expected %h actual %h",
							$time, exp_r.read_value, got.read_value);
						errors++;
					end
					if (got.status !== exp_r.status) begin
						$display("%0t: status expected %0b actual %0b",
							$time, exp_r.status, got.status);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_rsps.push_back(apply_request('{req_type, key, value}));
		end
	end

	// Driver: one transfer at a time from the pending queue, random gaps.
	always @(negedge clk) begin
		req_t rq;
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle);
		if (!in_valid || req_sent) begin
			if (arst_n && pending_reqs.size() > 0
					&& $urandom_range(99) >= send_idle) begin
				rq = pending_reqs.pop_front();
				in_valid <= 1'b1;
				req_type <= rq.req_type;
				key      <= rq.key;
				value    <= rq.value;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Dense key pool: 7 varying bits give at most 128 slots per table,
	// so the tables crowd and evictions chain.
	function automatic logic [31:0] pool_key(logic [31:0] base);
		logic [6:0] b;
		b = 7'($urandom);
		return base ^ {19'd0, b[6:4], 6'd0, b[3:0]};
	endfunction

	function automatic req_t random_req(logic [31:0] base);
		req_t rq;
		int   pick;
		pick = $urandom_range(99);
		rq.req_type = ($urandom_range(99) < 60) ? REQ_SET : REQ_LOOKUP;
		if (pick < 70)
			rq.key = pool_key(base);
		else if (pick < 85)
			rq.key = $urandom;
		else
			rq.key = {16'($urandom), 16'(pool_key(base))};
		case ($urandom_range(9))
			0:       rq.value = '0;
			1:       rq.value = '1;
			default: rq.value = $urandom;
		endcase
		return rq;
	endfunction

	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_kicks(logic [7:0] v);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic run_phase(logic [7:0] kicks, int s_idle, int r_idle, int count);
		logic [31:0] base;
		base = $urandom;
		write_kicks(kicks);
		send_idle = s_idle;
		recv_idle = r_idle;
		for (int i = 0; i < count; i++) begin
			pending_reqs.push_back(random_req(base));
			// Once per phase, at the halfway point, stop feeding until every result is back.
			if (i == count / 2)
				wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		errors     = 0;
		kick_limit = sch_pkg::KicksReset;
		send_idle  = 36;
		recv_idle  = 83;
		req_sent   = 1'b0;
		foreach (shadow_a[i]) shadow_a[i] = '0;
		foreach (shadow_b[i]) shadow_b[i] = '0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		req_type  = REQ_LOOKUP;
		key       = '0;
		value     = '0;
		out_ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: misses, zero item, extremes, update, tag aliasing.
		pending_reqs.push_back('{REQ_LOOKUP, 32'h0000_0000, 32'hffff_ffff});
		pending_reqs.push_back('{REQ_SET,    32'h0000_0000, 32'h0000_0000});
		pending_reqs.push_back('{REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000});
		pending_reqs.push_back('{REQ_SET,    32'hffff_ffff, 32'hffff_ffff});
		pending_reqs.push_back('{REQ_LOOKUP, 32'hffff_ffff, 32'h0000_0000});
		pending_reqs.push_back('{REQ_SET,    32'hffff_ffff, 32'h1234_5678});
		pending_reqs.push_back('{REQ_LOOKUP, 32'hffff_ffff, 32'hdead_beef});
		pending_reqs.push_back('{REQ_SET,    32'h0000_0000, 32'h0000_0001});
		pending_reqs.push_back('{REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000});
		pending_reqs.push_back('{REQ_LOOKUP, 32'h0001_ffff, 32'h0000_0000});
		pending_reqs.push_back('{REQ_SET,    32'h0001_ffff, 32'h0000_00aa});
		pending_reqs.push_back('{REQ_LOOKUP, 32'h0001_ffff, 32'h0000_0000});
		pending_reqs.push_back('{REQ_LOOKUP, 32'h8000_0001, 32'h0000_0000});
		pending_reqs.push_back('{REQ_SET,    32'h8000_0000, 32'h8000_0000});
		pending_reqs.push_back('{REQ_LOOKUP, 32'h8000_0000, 32'h0000_0000});
		for (int i = 0; i < 8; i++)
			pending_reqs.push_back('{REQ_SET, pool_key(32'h00c0_0400), $urandom});
		wait_drained();

		// Zero kick limit still evicts once before giving up.
		run_phase(8'd0, 36, 83, 200);
		run_phase(8'd255, 36, 83, 200);
		run_phase(8'd1, 83, 36, 250);
		run_phase(8'($urandom_range(2, 254)), 83, 36, 200);
		run_phase(sch_pkg::KicksReset, 0, 0, 300);

		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("[skewed_cuckoo_hash_table] OK");
		else
			$display("[skewed_cuckoo_hash_table] ERROR");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("[skewed_cuckoo_hash_table] ERROR");
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+design
design/sch_pkg.sv
design/sch_ram.sv
design/skewed_cuckoo_hash_table.sv
design/sch_checker.sv
bench/tb_skewed_cuckoo_hash_table.sv
